[hw/rtl/upq_pkg.sv]
package upq_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int WORD_W       = 32;
	localparam int OCC_OUT_W    = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [1:0]               mode_t;
	typedef logic [1:0]               status_t;
	typedef logic [OCC_OUT_W-1:0]     occ_out_t;

	localparam mode_t MODE_ENQ      = 2'd0;
	localparam mode_t MODE_DEQ      = 2'd1;
	localparam mode_t MODE_PEEK_OLD = 2'd2;
	localparam mode_t MODE_PEEK_NEW = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		status_t status;
		word_t   value;
		word_t   prio;
	} res_t;

endpackage

[hw/rtl/upq_ram.sv]
module upq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/unsorted_priority_queue.sv]
// Channel  Valid      Stall      Payload
// request  req_valid  req_stall  mode, entry_value, entry_priority
// response rsp_valid  rsp_stall  status, out_value, out_priority, occupancy_out
//
// Enqueue and empty/full outcomes go straight to the finish state; peeks make one RAM read.
// Dequeue reads every held entry once for the minimum, then moves each newer
// entry down one slot through the single RAM port pair.
// Reset clears the count and control registers, not the slots; slots are never read before being written.
// req_stall is high while a transaction is in progress; a finished result
// waits in the response register while the next request is taken.
module unsorted_priority_queue #(
	parameter int CAPACITY = upq_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  upq_pkg::mode_t    mode,
	input  upq_pkg::word_t    entry_value,
	input  upq_pkg::word_t    entry_priority,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output upq_pkg::status_t  status,
	output upq_pkg::word_t    out_value,
	output upq_pkg::word_t    out_priority,
	output upq_pkg::occ_out_t occupancy_out
);
	import upq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int DW = 2 * WORD_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PEEK   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   occ_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   occ_m1;
	logic [AW-1:0]   idx_s1;
	logic            vld_s1;
	logic [AW-1:0]   best_q;
	logic [AW-1:0]   best_nxt;
	word_t           best_val_q;
	word_t           best_pri_q;
	res_t            res_q;
	logic            rsp_valid_q;
	res_t            rsp_q;
	occ_out_t        rsp_occ_q;

	logic            accept;
	logic            full;
	logic            empty;
	logic            issue;
	logic            take;
	logic            walking;
	word_t           rd_val;
	word_t           rd_pri;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [DW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [DW-1:0]   ram_rdata;

	upq_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept   = req_valid && (state_q == S_IDLE);
	assign full     = (occ_q == CW'(CAPACITY));
	assign empty    = (occ_q == '0);
	assign occ_m1   = occ_q - CW'(1);
	assign issue    = (cnt_q < occ_q);
	assign walking  = (state_q == S_SCAN) || (state_q == S_SHIFT);
	assign rd_val   = ram_rdata[WORD_W-1:0];
	assign rd_pri   = ram_rdata[DW-1:WORD_W];
	assign take     = vld_s1 && ((idx_s1 == '0) || (rd_pri <= best_pri_q));
	assign best_nxt = take ? idx_s1 : best_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = occ_q[AW-1:0];
		ram_wdata = {entry_priority, entry_value};
		ram_re    = 1'b0;
		ram_raddr = cnt_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && mode == MODE_ENQ && !full) begin
					ram_we = 1'b1;
				end
				if (accept && !empty && (mode == MODE_PEEK_OLD || mode == MODE_PEEK_NEW)) begin
					ram_re    = 1'b1;
					ram_raddr = (mode == MODE_PEEK_OLD) ? '0 : occ_m1[AW-1:0];
				end
			end
			S_SCAN: begin
				ram_re = issue;
			end
			S_SHIFT: begin
				ram_re    = issue;
				ram_we    = vld_s1;
				ram_waddr = idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			best_q      <= '0;
			best_val_q  <= '0;
			best_pri_q  <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			rsp_occ_q   <= '0;
		end else begin
			vld_s1 <= walking && issue;
			idx_s1 <= cnt_q[AW-1:0];
			if (walking && issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_ENQ: begin
								if (full) begin
									res_q <= '{status: ST_FULL, value: '0, prio: '0};
								end else begin
									occ_q <= occ_q + CW'(1);
									res_q <= '{status: ST_OK, value: '0, prio: '0};
								end
								state_q <= S_FINISH;
							end
							MODE_DEQ: begin
								if (empty) begin
									res_q   <= '{status: ST_EMPTY, value: '0, prio: '0};
									state_q <= S_FINISH;
								end else begin
									cnt_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								if (empty) begin
									res_q   <= '{status: ST_EMPTY, value: '0, prio: '0};
									state_q <= S_FINISH;
								end else begin
									state_q <= S_PEEK;
								end
							end
						endcase
					end
				end
				S_PEEK: begin
					res_q   <= '{status: ST_OK, value: rd_val, prio: rd_pri};
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					if (vld_s1) begin
						best_q <= best_nxt;
						if (take) begin
							best_val_q <= rd_val;
							best_pri_q <= rd_pri;
						end
						if (idx_s1 == occ_m1[AW-1:0]) begin
							cnt_q   <= CW'(best_nxt) + CW'(1);
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (!issue && !vld_s1) begin
						occ_q   <= occ_m1;
						res_q   <= '{status: ST_OK, value: best_val_q, prio: best_pri_q};
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						rsp_occ_q   <= OCC_OUT_W'(occ_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall     = (state_q != S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_q.status;
	assign out_value     = rsp_q.value;
	assign out_priority  = rsp_q.prio;
	assign occupancy_out = rsp_occ_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |->
			(occ_q == $past(occ_q) + CW'(1) || occ_q == $past(occ_q) - CW'(1)))
		else $error("occupancy moved by more than one");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("response raised outside finish");

	a_shift_write_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_we) |-> (CW'(ram_waddr) < occ_m1))
		else $error("compaction write beyond held entries");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_PEEK) |-> !ram_we)
		else $error("store written during a read-only phase");

endmodule

[sim/unsorted_priority_queue_tb.sv]
`timescale 1ns / 100ps

module unsorted_priority_queue_tb;
	import upq_pkg::*;

	localparam int DEPTH        = DEF_CAPACITY;
	localparam int RANDOM_OPS   = 1850;
	localparam int SETTLE_EVERY = 400;
	localparam int TAIL_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		mode_t op;
		word_t value;
		word_t prio;
		bit    hold;
	} queue_req_t;

	typedef struct {
		status_t  status;
		word_t    value;
		word_t    prio;
		occ_out_t occ;
	} queue_rsp_t;

	logic     clk            = 1'b0;
	logic     arst_n         = 1'b0;
	logic     req_valid      = 1'b0;
	logic     req_stall;
	mode_t    mode           = MODE_ENQ;
	word_t    entry_value    = '0;
	word_t    entry_priority = '0;
	logic     rsp_valid;
	logic     rsp_stall      = 1'b0;
	status_t  status;
	word_t    out_value;
	word_t    out_priority;
	occ_out_t occupancy_out;

	queue_req_t op_backlog[$];
	queue_req_t next_req;
	queue_rsp_t pending_results[$];
	queue_rsp_t want;

	// shadow of the entry store, slot 0 oldest
	word_t shadow_value[DEPTH];
	word_t shadow_prio[DEPTH];
	int    shadow_count = 0;

	int ops_taken    = 0;
	int results_seen = 0;
	int req_gap      = 0;
	int sink_hold    = 0;
	int cycle_cnt    = 0;
	bit settled      = 1'b0;
	bit send_calm    = 1'b0;
	bit sink_calm    = 1'b0;
	bit failed       = 1'b0;

	unsorted_priority_queue #(
		.CAPACITY(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.entry_value(entry_value),
		.entry_priority(entry_priority),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.out_value(out_value),
		.out_priority(out_priority),
		.occupancy_out(occupancy_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 75)
			return 0;
		if (r < 97)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// expected outcome of one queue operation; updates the shadow store
	function automatic void apply_queue_op(mode_t op, word_t val, word_t pri);
		queue_rsp_t r;
		int best;
		int i;
		r.status = ST_OK;
		r.value  = '0;
		r.prio   = '0;
		if (op == MODE_ENQ) begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_value[shadow_count] = val;
				shadow_prio[shadow_count]  = pri;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_EMPTY;
		end else if (op == MODE_PEEK_OLD) begin
			r.value = shadow_value[0];
			r.prio  = shadow_prio[0];
		end else if (op == MODE_PEEK_NEW) begin
			r.value = shadow_value[shadow_count-1];
			r.prio  = shadow_prio[shadow_count-1];
		end else begin
			// newest of equal priorities wins
			best = 0;
			for (i = 1; i < shadow_count; i++)
				if (!(shadow_prio[best] < shadow_prio[i]))
					best = i;
			r.value = shadow_value[best];
			r.prio  = shadow_prio[best];
			for (i = best; i < shadow_count - 1; i++) begin
				shadow_value[i] = shadow_value[i+1];
				shadow_prio[i]  = shadow_prio[i+1];
			end
			shadow_count--;
		end
		r.occ = occ_out_t'(shadow_count);
		pending_results.push_back(r);
	endfunction

	function automatic void check_field(string field, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			failed = 1'b1;
			$display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
		end
	endfunction

	task automatic queue_request(mode_t op, word_t v, word_t p, bit hold);
		queue_req_t q;
		q.op    = op;
		q.value = v;
		q.prio  = p;
		q.hold  = hold;
		op_backlog.push_back(q);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid      <= 1'b0;
			mode           <= MODE_ENQ;
			entry_value    <= '0;
			entry_priority <= '0;
			req_gap        <= 0;
			settled        <= 1'b0;
			send_calm      <= 1'b0;
		end else begin
			if ($urandom_range(0, 149) == 0)
				send_calm <= !send_calm;
			if (req_valid && !req_stall) begin
				apply_queue_op(mode, entry_value, entry_priority);
				ops_taken <= ops_taken + 1;
			end
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_valid <= 1'b0;
					req_gap   <= req_gap - 1;
				end else if (op_backlog.size() == 0) begin
					req_valid <= 1'b0;
				end else if (op_backlog[0].hold && !settled) begin
					// hold off until every outstanding transaction has returned
					req_valid <= 1'b0;
					if (!req_valid && ops_taken == results_seen)
						settled <= 1'b1;
				end else begin
					next_req        = op_backlog.pop_front();
					req_valid      <= 1'b1;
					mode           <= next_req.op;
					entry_value    <= next_req.value;
					entry_priority <= next_req.prio;
					settled        <= 1'b0;
					req_gap        <= pick_gap(send_calm);
				end
			end
		end
	end

	// response monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			sink_hold <= 0;
			sink_calm <= 1'b0;
		end else begin
			if ($urandom_range(0, 149) == 0)
				sink_calm <= !sink_calm;
			if (rsp_valid && !rsp_stall) begin
				results_seen <= results_seen + 1;
				if (pending_results.size() == 0) begin
					failed = 1'b1;
					$display("%0t: unexpected transaction: status %0d value %0d priority %0d",
						$time, status, out_value, out_priority);
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("out_value", want.value, out_value);
					check_field("out_priority", want.prio, out_priority);
					check_field("occupancy_out", want.occ, occupancy_out);
				end
			end
			if (sink_hold != 0) begin
				rsp_stall <= 1'b1;
				sink_hold <= sink_hold - 1;
			end else begin
				rsp_stall <= 1'b0;
				sink_hold <= pick_gap(sink_calm);
			end
		end
	end

	initial begin
		bit    timed_out;
		int    n;
		int    k;
		int    r;
		int    style;
		int    span;
		int    enq_pct;
		int    deq_pct;
		mode_t op;
		word_t pri;

		timed_out = 1'b0;

		// operations on an empty queue
		queue_request(MODE_DEQ, $urandom, $urandom, 1'b0);
		queue_request(MODE_PEEK_OLD, $urandom, $urandom, 1'b0);
		queue_request(MODE_PEEK_NEW, $urandom, $urandom, 1'b0);
		// fill to capacity with extreme values and ties
		queue_request(MODE_ENQ, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
		queue_request(MODE_ENQ, 32'h80000000, 32'h80000000, 1'b0);
		queue_request(MODE_ENQ, 32'h00000000, 32'h00000000, 1'b0);
		queue_request(MODE_ENQ, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		queue_request(MODE_ENQ, 32'h55555555, 32'sd5, 1'b0);
		queue_request(MODE_ENQ, 32'hAAAAAAAA, 32'sd5, 1'b0);
		queue_request(MODE_ENQ, 32'sd1, 32'h80000000, 1'b0);
		for (k = 0; k < 8; k++)
			queue_request(MODE_ENQ, $urandom, $urandom, 1'b0);
		queue_request(MODE_ENQ, 32'h13579BDF, 32'h80000000, 1'b0);
		queue_request(MODE_ENQ, $urandom, $urandom, 1'b0);
		queue_request(MODE_PEEK_OLD, $urandom, $urandom, 1'b0);
		queue_request(MODE_PEEK_NEW, $urandom, $urandom, 1'b0);
		// newest entry is the newest of the minimum ties, so the rear must move back
		queue_request(MODE_DEQ, $urandom, $urandom, 1'b0);
		queue_request(MODE_PEEK_NEW, $urandom, $urandom, 1'b0);
		queue_request(MODE_DEQ, $urandom, $urandom, 1'b0);

		// random episodes: filling, draining or mixed
		n = 0;
		while (n < RANDOM_OPS) begin
			style = $urandom_range(0, 2);
			span  = $urandom_range(8, 60);
			case (style)
				0: begin
					enq_pct = 75;
					deq_pct = 15;
				end
				1: begin
					enq_pct = 20;
					deq_pct = 70;
				end
				default: begin
					enq_pct = 45;
					deq_pct = 40;
				end
			endcase
			for (k = 0; k < span && n < RANDOM_OPS; k++) begin
				r = $urandom_range(0, 99);
				if (r < enq_pct)
					op = MODE_ENQ;
				else if (r < enq_pct + deq_pct)
					op = MODE_DEQ;
				else if ($urandom_range(0, 1) == 0)
					op = MODE_PEEK_OLD;
				else
					op = MODE_PEEK_NEW;
				r = $urandom_range(0, 9);
				if (r < 4) begin
					pri = $urandom_range(0, 7);
				end else if (r == 4) begin
					case ($urandom_range(0, 3))
						0: pri = 32'h80000000;
						1: pri = 32'h7FFFFFFF;
						2: pri = 32'hFFFFFFFF;
						default: pri = 32'h00000000;
					endcase
				end else begin
					pri = $urandom;
				end
				queue_request(op, $urandom, pri, (n % SETTLE_EVERY) == 0);
				n++;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			begin
				while (op_backlog.size() != 0 || req_valid)
					@(negedge clk);
				while (results_seen != ops_taken)
					@(negedge clk);
				repeat (TAIL_CYCLES) @(negedge clk);
			end
			begin
				while (cycle_cnt < CYCLE_LIMIT)
					@(negedge clk);
				timed_out = 1'b1;
			end
		join_any

		if (!timed_out && !failed && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hw/rtl/upq_pkg.sv
hw/rtl/upq_ram.sv
hw/rtl/unsorted_priority_queue.sv
sim/unsorted_priority_queue_tb.sv
